// ===== design/srpq_pkg.sv =====
`default_nettype none

package srpq_pkg;

    // Ring storage geometry
    localparam int DEPTH   = 16;
    localparam int IDX_W   = $clog2(DEPTH);
    localparam int CNT_W   = $clog2(DEPTH + 1);
    localparam int PRIO_W  = 8;
    localparam int DATA_W  = 8;
    localparam int ENTRY_W = PRIO_W + DATA_W;

    // Stream word widths
    localparam int S_TDATA_W = 16;
    localparam int M_TDATA_W = 24;
    localparam int STATUS_W  = 2;

    // Operation kinds
    localparam logic KIND_INSERT = 1'b0;
    localparam logic KIND_REMOVE = 1'b1;

    // Result status codes
    localparam logic [STATUS_W-1:0] STATUS_DONE       = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_FULL       = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_EMPTY      = 2'd2;

    typedef logic [IDX_W-1:0]   t_idx;
    typedef logic [CNT_W-1:0]   t_cnt;
    typedef logic [ENTRY_W-1:0] t_entry;

endpackage

`default_nettype wire

// ===== design/sorted_ring_priority_queue.sv =====
`default_nettype none
// A remove passes through ST_RDWT; rejections and the first insert go straight to ST_DONE;
// other inserts walk ST_SHIFT, one entry compared and moved back per step, then ST_FIX if needed.
// One operation at a time: the next word is accepted in the cycle after the result loads,
// and a stalled result holds the block in ST_DONE.
// Reset (i_rst_n low, synchronous): queue empty, capacity 16, no result pending; the entry
// store is not cleared, only written slots are ever read. A capacity write empties the queue.
module sorted_ring_priority_queue (
    input  wire                              i_clk,
    input  wire                              i_rst_n,
    // Capacity register
    input  wire                              i_cfg_we,
    input  wire  [srpq_pkg::CNT_W-1:0]       i_cfg_wdata,
    // Operation stream
    input  wire                              i_s_tvalid,
    output logic                             o_s_tready,
    input  wire  [srpq_pkg::S_TDATA_W-1:0]   i_s_tdata,   // [7:0] item_prio, [15:8] item_data
    input  wire                              i_s_tuser,   // [0] kind
    // Result stream
    output logic                             o_m_tvalid,
    input  wire                              i_m_tready,
    output logic [srpq_pkg::M_TDATA_W-1:0]   o_m_tdata,   // [7:0] out_prio, [15:8] out_data,
                                                          // [20:16] entry_count, [23:21] zero
    output logic [srpq_pkg::STATUS_W-1:0]    o_m_tuser    // [1:0] status
);
    import srpq_pkg::*;

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_RDWT  = 3'd1;
    localparam logic [2:0] ST_SHIFT = 3'd2;
    localparam logic [2:0] ST_FIX   = 3'd3;
    localparam logic [2:0] ST_DONE  = 3'd4;

    // Entry store, registered read
    t_entry r_mem [DEPTH];
    t_entry r_rdata;

    logic [2:0]          r_state, n_state;
    t_idx                r_head, n_head;
    t_idx                r_tail, n_tail;
    logic                r_empty, n_empty;
    t_cnt                r_cap;
    t_idx                r_i, n_i;
    logic [PRIO_W-1:0]   r_prio;
    logic [DATA_W-1:0]   r_data;
    logic [STATUS_W-1:0] r_status, n_status;
    logic [PRIO_W-1:0]   r_res_prio, n_res_prio;
    logic [DATA_W-1:0]   r_res_data, n_res_data;

    logic                r_out_valid;
    logic [PRIO_W-1:0]   r_out_prio;
    logic [DATA_W-1:0]   r_out_data;
    t_cnt                r_out_count;
    logic [STATUS_W-1:0] r_out_status;

    logic   mem_we;
    t_idx   mem_waddr;
    t_entry mem_wdata;
    t_idx   mem_raddr;

    logic   accept;
    logic   out_free;
    t_cnt   count;
    t_cnt   cap_eff;
    t_idx   tail_next;
    t_idx   i_next;
    t_idx   i_prev;
    t_entry item;

    // Clamp the capacity to 1..DEPTH
    always_comb begin
        if (r_cap == '0) begin
            cap_eff = t_cnt'(1);
        end else if (r_cap > t_cnt'(DEPTH)) begin
            cap_eff = t_cnt'(DEPTH);
        end else begin
            cap_eff = r_cap;
        end
    end

    // Entries held, from head, tail and the empty flag
    always_comb begin
        if (r_empty) begin
            count = '0;
        end else if (r_tail >= r_head) begin
            count = t_cnt'({1'b0, r_tail} - {1'b0, r_head} + t_cnt'(1));
        end else begin
            count = t_cnt'({1'b0, r_tail} + cap_eff - {1'b0, r_head} + t_cnt'(1));
        end
    end

    // Ring neighbors
    assign tail_next = (t_cnt'({1'b0, r_tail} + t_cnt'(1)) >= cap_eff) ? '0 : r_tail + t_idx'(1);
    assign i_next    = (t_cnt'({1'b0, r_i} + t_cnt'(1)) >= cap_eff) ? '0 : r_i + t_idx'(1);
    assign i_prev    = (r_i == '0) ? t_idx'(cap_eff - t_cnt'(1)) : r_i - t_idx'(1);

    assign item       = {r_prio, r_data};
    assign o_s_tready = (r_state == ST_IDLE);
    assign accept     = i_s_tvalid && o_s_tready;
    assign out_free   = !r_out_valid || i_m_tready;

    // Sequencer: one compare-and-move of the entry store per cycle
    always_comb begin
        n_state    = r_state;
        n_head     = r_head;
        n_tail     = r_tail;
        n_empty    = r_empty;
        n_i        = r_i;
        n_status   = r_status;
        n_res_prio = r_res_prio;
        n_res_data = r_res_data;
        mem_we     = 1'b0;
        mem_waddr  = '0;
        mem_wdata  = {i_s_tdata[7:0], i_s_tdata[15:8]};
        mem_raddr  = r_i;
        case (r_state)
            ST_IDLE: begin
                mem_raddr = (i_s_tuser == KIND_REMOVE) ? r_head : r_tail;
                if (accept) begin
                    n_status   = STATUS_DONE;
                    n_res_prio = '0;
                    n_res_data = '0;
                    if (i_s_tuser == KIND_INSERT) begin
                        if (r_empty) begin
                            // First entry goes to slot zero
                            mem_we    = 1'b1;
                            mem_waddr = '0;
                            n_head    = '0;
                            n_tail    = '0;
                            n_empty   = 1'b0;
                            n_state   = ST_DONE;
                        end else if (count >= cap_eff) begin
                            n_status = STATUS_FULL;
                            n_state  = ST_DONE;
                        end else begin
                            // Open a slot at the tail and walk back from the old tail
                            n_tail  = tail_next;
                            n_i     = r_tail;
                            n_state = ST_SHIFT;
                        end
                    end else begin
                        if (r_empty) begin
                            n_status = STATUS_EMPTY;
                            n_state  = ST_DONE;
                        end else begin
                            n_state = ST_RDWT;
                        end
                    end
                end
            end
            ST_RDWT: begin
                // Head entry is out of the store; advance or drain
                n_res_prio = r_rdata[ENTRY_W-1:DATA_W];
                n_res_data = r_rdata[DATA_W-1:0];
                if (r_head == r_tail) begin
                    n_head  = '0;
                    n_tail  = '0;
                    n_empty = 1'b1;
                end else begin
                    n_head = (t_cnt'({1'b0, r_head} + t_cnt'(1)) >= cap_eff) ? '0
                                                                          : r_head + t_idx'(1);
                end
                n_state = ST_DONE;
            end
            ST_SHIFT: begin
                mem_we    = 1'b1;
                mem_waddr = i_next;
                mem_raddr = i_prev;
                if (r_rdata[ENTRY_W-1:DATA_W] <= r_prio) begin
                    mem_wdata = item;
                    n_state   = ST_DONE;
                end else begin
                    mem_wdata = r_rdata;
                    if (r_i == r_head) begin
                        n_state = ST_FIX;
                    end else begin
                        n_i = i_prev;
                    end
                end
            end
            ST_FIX: begin
                // New entry becomes the head
                mem_we    = 1'b1;
                mem_waddr = r_head;
                mem_wdata = item;
                n_state   = ST_DONE;
            end
            ST_DONE: begin
                if (out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // Store write and registered read
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_waddr] <= mem_wdata;
        end
        r_rdata <= r_mem[mem_raddr];
    end

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_head  <= '0;
            r_tail  <= '0;
            r_empty <= 1'b1;
            r_cap   <= t_cnt'(DEPTH);
        end else if (i_cfg_we) begin
            r_state <= n_state;
            r_head  <= '0;
            r_tail  <= '0;
            r_empty <= 1'b1;
            r_cap   <= i_cfg_wdata;
        end else begin
            r_state <= n_state;
            r_head  <= n_head;
            r_tail  <= n_tail;
            r_empty <= n_empty;
        end
    end

    // Operation payload and working registers
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_prio <= i_s_tdata[7:0];
            r_data <= i_s_tdata[15:8];
        end
        r_i        <= n_i;
        r_status   <= n_status;
        r_res_prio <= n_res_prio;
        r_res_data <= n_res_data;
    end

    // Result register: load when done, drop when taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (r_state == ST_DONE && out_free) begin
            r_out_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == ST_DONE && out_free) begin
            r_out_prio   <= r_res_prio;
            r_out_data   <= r_res_data;
            r_out_count  <= count;
            r_out_status <= r_status;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {(M_TDATA_W - CNT_W - DATA_W - PRIO_W)'(0),
                         r_out_count, r_out_data, r_out_prio};
    assign o_m_tuser  = r_out_status;

endmodule

`default_nettype wire

// ===== sim/sorted_ring_priority_queue_tb.sv =====
`default_nettype none

module sorted_ring_priority_queue_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import srpq_pkg::*;

    localparam int CYCLE_LIMIT  = 300000;
    localparam int SETTLE_TAIL  = DEPTH + 6;
    localparam int REPORT_LIMIT = 10;

    typedef struct packed {
        logic [PRIO_W-1:0]   prio;
        logic [DATA_W-1:0]   data;
        t_cnt                count;
        logic [STATUS_W-1:0] status;
    } t_result;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 i_cfg_we = 1'b0;
    logic [CNT_W-1:0]     i_cfg_wdata = '0;
    logic                 i_s_tvalid = 1'b0;
    logic                 o_s_tready;
    logic [S_TDATA_W-1:0] i_s_tdata = '0;
    logic                 i_s_tuser = 1'b0;
    logic                 o_m_tvalid;
    logic                 i_m_tready = 1'b0;
    logic [M_TDATA_W-1:0] o_m_tdata;
    logic [STATUS_W-1:0]  o_m_tuser;

    // Shadow copy of the queue state
    t_entry           shadow_ring [DEPTH];
    int unsigned      shadow_head;
    int unsigned      shadow_tail;
    bit               shadow_empty;
    logic [CNT_W-1:0] shadow_capacity;

    t_result pending_results [$];
    int      mismatch_count = 0;
    int      cycle_count = 0;
    bit      idle_on = 1'b1;
    int      hold_len = 0;

    sorted_ring_priority_queue u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_s_tvalid  (i_s_tvalid),
        .o_s_tready  (o_s_tready),
        .i_s_tdata   (i_s_tdata),
        .i_s_tuser   (i_s_tuser),
        .o_m_tvalid  (o_m_tvalid),
        .i_m_tready  (i_m_tready),
        .o_m_tdata   (o_m_tdata),
        .o_m_tuser   (o_m_tuser)
    );

    initial begin
        forever #10 i_clk = ~i_clk;
    end

    // Abort a hung run
    initial begin
        forever begin
            @(posedge i_clk);
            cycle_count++;
            if (cycle_count > CYCLE_LIMIT) begin
                $display("== FAIL ==");
                $finish;
            end
        end
    end

    // Clamp the capacity register to a usable ring size
    function automatic int unsigned ring_size();
        int unsigned c;
        c = shadow_capacity;
        if (c == 0) c = 1;
        if (c > DEPTH) c = DEPTH;
        return c;
    endfunction

    function automatic int unsigned entries_held(int unsigned c);
        if (shadow_empty) return 0;
        return ((shadow_tail + c - shadow_head) % c) + 1;
    endfunction

    // Apply one operation to the shadow queue and return the result word it yields
    function automatic t_result pq_apply(logic kind, logic [PRIO_W-1:0] prio,
                                         logic [DATA_W-1:0] data);
        t_result     r;
        int unsigned c;
        int unsigned i;
        int unsigned j;
        t_entry      entry;
        bit          placed;
        c = ring_size();
        r = '0;
        entry = {prio, data};
        shadow_head = shadow_head % c;
        shadow_tail = shadow_tail % c;
        if (kind == KIND_INSERT) begin
            if (shadow_empty) begin
                shadow_head = 0;
                shadow_tail = 0;
                shadow_ring[0] = entry;
                shadow_empty = 1'b0;
            end else if (entries_held(c) >= c) begin
                r.status = STATUS_FULL;
            end else begin
                // Grow the tail, then shift larger priorities back until the gap fits
                shadow_tail = (shadow_tail + 1 >= c) ? 0 : shadow_tail + 1;
                i = (shadow_tail == 0) ? c - 1 : shadow_tail - 1;
                placed = 1'b0;
                while (!placed) begin
                    j = (i + 1 >= c) ? 0 : i + 1;
                    if (shadow_ring[i][ENTRY_W-1:DATA_W] <= prio) begin
                        shadow_ring[j] = entry;
                        placed = 1'b1;
                    end else begin
                        shadow_ring[j] = shadow_ring[i];
                        if (i == shadow_head) begin
                            shadow_ring[i] = entry;
                            placed = 1'b1;
                        end else begin
                            i = (i == 0) ? c - 1 : i - 1;
                        end
                    end
                end
            end
        end else begin
            if (shadow_empty) begin
                r.status = STATUS_EMPTY;
            end else begin
                r.prio = shadow_ring[shadow_head][ENTRY_W-1:DATA_W];
                r.data = shadow_ring[shadow_head][DATA_W-1:0];
                if (shadow_head == shadow_tail) begin
                    shadow_head = 0;
                    shadow_tail = 0;
                    shadow_empty = 1'b1;
                end else begin
                    shadow_head = (shadow_head + 1 >= c) ? 0 : shadow_head + 1;
                end
            end
        end
        r.count = t_cnt'(entries_held(c));
        return r;
    endfunction

    // Offer one word after a random gap and record its expected result on accept
    task automatic send_op(logic kind, logic [PRIO_W-1:0] prio, logic [DATA_W-1:0] data);
        int gap;
        gap = idle_on ? $urandom_range(0, 15) : 0;
        if (gap > 0) begin
            i_s_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tdata  <= {data, prio};
        i_s_tuser  <= kind;
        do @(posedge i_clk); while (!o_s_tready);
        pending_results.push_back(pq_apply(kind, prio, data));
    endtask

    // Drop valid and wait for the block to drain and go idle
    task automatic settle();
        i_s_tvalid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (SETTLE_TAIL) @(posedge i_clk);
    endtask

    // Write capacity while idle; the write also empties the queue
    task automatic write_capacity(logic [CNT_W-1:0] value);
        settle();
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= value;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        shadow_capacity = value;
        shadow_head = 0;
        shadow_tail = 0;
        shadow_empty = 1'b1;
    endtask

    // Result side: random stall per word, plus an optional long hold-off
    initial begin
        int stall;
        forever begin
            if (hold_len > 0) begin
                i_m_tready <= 1'b0;
                while (hold_len > 0) begin
                    @(posedge i_clk);
                    hold_len--;
                end
            end
            stall = idle_on ? $urandom_range(0, 15) : 0;
            if (stall > 0) begin
                i_m_tready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            i_m_tready <= 1'b1;
            do @(posedge i_clk); while (!o_m_tvalid);
        end
    end

    // Compare each accepted result word with the oldest expectation
    initial begin
        t_result want;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && o_m_tvalid && i_m_tready) begin
                if (pending_results.size() == 0) begin
                    if (mismatch_count < REPORT_LIMIT)
                        $display("unexpected result word: tdata=%h tuser=%h",
                                 o_m_tdata, o_m_tuser);
                    mismatch_count++;
                end else begin
                    want = pending_results.pop_front();
                    if (o_m_tdata[PRIO_W-1:0] !== want.prio
                        || o_m_tdata[15:8] !== want.data
                        || o_m_tdata[16+CNT_W-1:16] !== want.count
                        || o_m_tdata[M_TDATA_W-1:16+CNT_W] !== '0
                        || o_m_tuser !== want.status) begin
                        if (mismatch_count < REPORT_LIMIT) begin
                            $display("result mismatch: exp prio=%h data=%h count=%0d status=%0d",
                                     want.prio, want.data, want.count, want.status);
                            $display("  got prio=%h data=%h count=%0d pad=%h status=%0d",
                                     o_m_tdata[7:0], o_m_tdata[15:8],
                                     o_m_tdata[16+CNT_W-1:16],
                                     o_m_tdata[M_TDATA_W-1:16+CNT_W], o_m_tuser);
                        end
                        mismatch_count++;
                    end
                end
            end
        end
    end

    // Pick priorities with extremes and frequent ties
    function automatic logic [PRIO_W-1:0] pick_prio();
        int unsigned r;
        r = $urandom_range(0, 9);
        case (r)
            0: return '0;
            1: return '1;
            2, 3, 4: return PRIO_W'($urandom_range(100, 103));
            default: return PRIO_W'($urandom_range(0, 255));
        endcase
    endfunction

    // Empty remove, extreme fields, ties kept in arrival order, shift past all entries
    task automatic test_ordering();
        idle_on = 1'b1;
        send_op(KIND_REMOVE, 8'h00, 8'h00);
        send_op(KIND_INSERT, 8'hFF, 8'hFF);
        send_op(KIND_INSERT, 8'h80, 8'hA5);
        send_op(KIND_INSERT, 8'h80, 8'h5A);
        send_op(KIND_INSERT, 8'h80, 8'h01);
        send_op(KIND_INSERT, 8'h00, 8'h00);
        send_op(KIND_INSERT, 8'h7F, 8'h33);
        repeat (6) send_op(KIND_REMOVE, 8'hFF, 8'hFF);
        send_op(KIND_REMOVE, 8'h55, 8'hAA);
    endtask

    // Capacity zero acts as one: full and empty rejections on a single slot
    task automatic test_capacity_limits();
        logic [CNT_W-1:0] value;
        for (int k = 0; k < 2; k++) begin
            value = (k == 0) ? CNT_W'(0) : CNT_W'(1);
            write_capacity(value);
            send_op(KIND_INSERT, 8'h10, 8'h11);
            send_op(KIND_INSERT, 8'h01, 8'h22);
            send_op(KIND_REMOVE, 8'h00, 8'h00);
            send_op(KIND_REMOVE, 8'h00, 8'h00);
        end
    endtask

    // Alternate fill-heavy and drain-heavy stretches to reach full, empty and wrap
    task automatic test_random_phase(logic [CNT_W-1:0] value, int op_total, bit idle,
                                     int hold);
        int seg;
        int fill_pct;
        logic kind;
        write_capacity(value);
        idle_on = idle;
        hold_len = hold;
        seg = 0;
        fill_pct = 20;
        for (int k = 0; k < op_total; k++) begin
            if (seg == 0) begin
                seg = $urandom_range(1, 2 * ring_size() + 2);
                fill_pct = (fill_pct > 50) ? 20 : 85;
            end
            seg--;
            kind = ($urandom_range(0, 99) < fill_pct) ? KIND_INSERT : KIND_REMOVE;
            send_op(kind, pick_prio(), DATA_W'($urandom_range(0, 255)));
        end
    endtask

    task automatic test_random();
        logic [CNT_W-1:0] plan [12];
        plan = '{5'd16, 5'd1, 5'd0, 5'd2, 5'd17, 5'd31, 5'd5, 5'd10, 5'd3, 5'd16,
                 5'd0, 5'd0};
        plan[10] = CNT_W'($urandom_range(0, 31));
        plan[11] = CNT_W'($urandom_range(0, 31));
        for (int p = 0; p < 12; p++)
            test_random_phase(plan[p], 100, (p % 3) != 2, (p == 6) ? 400 : 0);
    endtask

    initial begin
        shadow_capacity = CNT_W'(DEPTH);
        shadow_head = 0;
        shadow_tail = 0;
        shadow_empty = 1'b1;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_ordering();
        test_capacity_limits();
        test_random();

        settle();
        if (mismatch_count == 0 && pending_results.size() == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule

`default_nettype wire

// ===== files.f =====
design/srpq_pkg.sv
design/sorted_ring_priority_queue.sv
sim/sorted_ring_priority_queue_tb.sv
